// ===== sv/wisp_pkg.sv =====
// Shared types and constants for the information-element security parser.
package wisp_pkg;

    // SSID buffer geometry: two banks of SSID_BYTES entries each
    localparam int SSID_BYTES = 32;
    localparam int SSID_AW    = $clog2(SSID_BYTES);
    localparam int MEM_AW     = SSID_AW + 1;
    localparam int LEN_W      = SSID_AW + 1;

    // Element types and cipher suites
    localparam logic [7:0]  KIND_SSID  = 8'd0;
    localparam logic [7:0]  KIND_RSN   = 8'd48;
    localparam logic [31:0] SUITE_PSK  = 32'h000F_AC02;
    localparam logic [31:0] SUITE_CCMP = 32'h000F_AC04;

    // Security class codes
    localparam logic [1:0] SEC_UNKNOWN = 2'd0;
    localparam logic [1:0] SEC_CCMP    = 2'd1;
    localparam logic [1:0] SEC_TKIP    = 2'd2;

    // Result kinds carried on tuser
    localparam logic RES_SSID    = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    // Drain request from the parser to the output side
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic [1:0]       sec;
    } drain_cmd_t;

    // SSID buffer write port
    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } ssid_wr_t;

    // Queue status seen by the parser
    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] pend;
    } fifo_stat_t;

    // Output side status: which bank is being read out
    typedef struct packed {
        logic active;
        logic bank;
    } back_stat_t;

endpackage

// ===== sv/wisp_front.sv =====
// Element parser: walks the TLV stream, stages SSID bytes and checks RSN bodies.
module wisp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  wisp_pkg::fifo_stat_t  fifo_stat,
    input  wisp_pkg::back_stat_t  back_stat,
    output logic                  push,
    output wisp_pkg::drain_cmd_t  push_cmd,
    output wisp_pkg::ssid_wr_t    ssid_wr
);
    import wisp_pkg::*;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef enum logic [3:0] {
        ST_VER_LO,
        ST_VER_HI,
        ST_GROUP,
        ST_PCNT_LO,
        ST_PCNT_HI,
        ST_PAIR,
        ST_ACNT_LO,
        ST_ACNT_HI,
        ST_AKM,
        ST_DONE,
        ST_FAIL
    } step_t;

    phase_t           phase_reg, phase_next;
    step_t            step_reg, step_next;
    logic [7:0]       kind_reg, kind_next;
    logic [7:0]       size_reg, size_next;
    logic [7:0]       rem_reg, rem_next;
    logic [23:0]      shift_reg, shift_next;
    logic [1:0]       sbyte_reg, sbyte_next;
    logic [15:0]      cnt_reg, cnt_next;
    logic             ccmp_reg, ccmp_next;
    logic             psk_reg, psk_next;
    logic [1:0]       grp_reg, grp_next;
    logic [LEN_W-1:0] clen_reg, clen_next;
    logic [1:0]       sec_reg, sec_next;
    logic             cbank_reg, cbank_next;

    logic        accept;
    logic        finish;
    logic        wr_cond;
    logic        bank_busy;
    logic [7:0]  idx;
    logic [31:0] suite;
    logic [1:0]  pend;

    // Banks still owed to the output side
    always_comb
    begin
        pend = fifo_stat.pend;
        if (back_stat.active)
        begin
            pend[back_stat.bank] = 1'b1;
        end
    end

    assign idx       = size_reg - rem_reg;
    assign wr_cond   = (phase_reg == PH_BODY) && (kind_reg == KIND_SSID)
                       && (idx < 8'(SSID_BYTES));
    assign bank_busy = pend[~cbank_reg];
    assign s_tready  = !fifo_stat.full && !(wr_cond && bank_busy);
    assign accept    = s_tvalid && s_tready;
    assign suite     = {shift_reg, s_tdata};

    // Stage SSID body bytes into the bank not holding the committed SSID
    assign ssid_wr.en   = accept && wr_cond;
    assign ssid_wr.addr = {~cbank_reg, idx[SSID_AW-1:0]};
    assign ssid_wr.data = s_tdata;

    // Parse one byte and work out the next state
    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        kind_next  = kind_reg;
        size_next  = size_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        sbyte_next = sbyte_reg;
        cnt_next   = cnt_reg;
        ccmp_next  = ccmp_reg;
        psk_next   = psk_reg;
        grp_next   = grp_reg;
        clen_next  = clen_reg;
        sec_next   = sec_reg;
        cbank_next = cbank_reg;
        finish     = 1'b0;
        push       = 1'b0;
        push_cmd   = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    kind_next  = s_tdata;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    size_next  = s_tdata;
                    rem_next   = s_tdata;
                    step_next  = ST_VER_LO;
                    shift_next = '0;
                    sbyte_next = '0;
                    cnt_next   = '0;
                    ccmp_next  = 1'b0;
                    psk_next   = 1'b0;
                    grp_next   = SEC_UNKNOWN;
                    if (s_tdata == 8'd0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (kind_reg == KIND_RSN)
                    begin
                        case (step_reg)
                            ST_VER_LO:
                            begin
                                shift_next = {16'd0, s_tdata};
                                step_next  = ST_VER_HI;
                            end
                            ST_VER_HI:
                            begin
                                if (shift_reg[7:0] == 8'd1 && s_tdata == 8'd0)
                                begin
                                    shift_next = '0;
                                    sbyte_next = '0;
                                    step_next  = ST_GROUP;
                                end
                                else
                                begin
                                    step_next = ST_FAIL;
                                end
                            end
                            ST_GROUP:
                            begin
                                shift_next = suite[23:0];
                                sbyte_next = sbyte_reg + 2'd1;
                                if (sbyte_reg == 2'd3)
                                begin
                                    if (suite == SUITE_PSK)
                                    begin
                                        grp_next = SEC_TKIP;
                                    end
                                    else if (suite == SUITE_CCMP)
                                    begin
                                        grp_next = SEC_CCMP;
                                    end
                                    else
                                    begin
                                        grp_next = SEC_UNKNOWN;
                                    end
                                    step_next = ST_PCNT_LO;
                                end
                            end
                            ST_PCNT_LO, ST_ACNT_LO:
                            begin
                                shift_next = {16'd0, s_tdata};
                                step_next  = (step_reg == ST_PCNT_LO) ? ST_PCNT_HI
                                                                      : ST_ACNT_HI;
                            end
                            ST_PCNT_HI:
                            begin
                                cnt_next   = {s_tdata, shift_reg[7:0]};
                                shift_next = '0;
                                sbyte_next = '0;
                                step_next  = (cnt_next != 16'd0) ? ST_PAIR : ST_ACNT_LO;
                            end
                            ST_ACNT_HI:
                            begin
                                cnt_next   = {s_tdata, shift_reg[7:0]};
                                shift_next = '0;
                                sbyte_next = '0;
                                step_next  = (cnt_next != 16'd0) ? ST_AKM : ST_DONE;
                            end
                            ST_PAIR, ST_AKM:
                            begin
                                shift_next = suite[23:0];
                                sbyte_next = sbyte_reg + 2'd1;
                                if (sbyte_reg == 2'd3)
                                begin
                                    if (step_reg == ST_PAIR && suite == SUITE_CCMP)
                                    begin
                                        ccmp_next = 1'b1;
                                    end
                                    if (step_reg == ST_AKM && suite == SUITE_PSK)
                                    begin
                                        psk_next = 1'b1;
                                    end
                                    shift_next = '0;
                                    cnt_next   = cnt_reg - 16'd1;
                                    if (cnt_reg == 16'd1)
                                    begin
                                        step_next = (step_reg == ST_PAIR) ? ST_ACNT_LO
                                                                          : ST_DONE;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    rem_next = rem_reg - 8'd1;
                    if (rem_reg == 8'd1)
                    begin
                        finish = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // Apply a complete element
            if (finish)
            begin
                phase_next = PH_TYPE;
                if (kind_reg == KIND_SSID)
                begin
                    cbank_next = ~cbank_reg;
                    clen_next  = (size_next < 8'(SSID_BYTES)) ? size_next[LEN_W-1:0]
                                                              : LEN_W'(SSID_BYTES);
                end
                else if (kind_reg == KIND_RSN)
                begin
                    if (step_next == ST_DONE && ccmp_next && psk_next
                        && grp_next != SEC_UNKNOWN)
                    begin
                        sec_next = grp_next;
                    end
                end
            end

            // Hand the blob result to the output side and clear for the next blob
            if (s_tlast)
            begin
                push          = 1'b1;
                push_cmd.bank = cbank_next;
                push_cmd.len  = clen_next;
                push_cmd.sec  = sec_next;
                phase_next    = PH_TYPE;
                step_next     = ST_VER_LO;
                kind_next     = '0;
                size_next     = '0;
                rem_next      = '0;
                shift_next    = '0;
                sbyte_next    = '0;
                cnt_next      = '0;
                ccmp_next     = 1'b0;
                psk_next      = 1'b0;
                grp_next      = SEC_UNKNOWN;
                clen_next     = '0;
                sec_next      = SEC_UNKNOWN;
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            step_reg  <= ST_VER_LO;
            kind_reg  <= '0;
            size_reg  <= '0;
            rem_reg   <= '0;
            shift_reg <= '0;
            sbyte_reg <= '0;
            cnt_reg   <= '0;
            ccmp_reg  <= 1'b0;
            psk_reg   <= 1'b0;
            grp_reg   <= SEC_UNKNOWN;
            clen_reg  <= '0;
            sec_reg   <= SEC_UNKNOWN;
            cbank_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            kind_reg  <= kind_next;
            size_reg  <= size_next;
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
            sbyte_reg <= sbyte_next;
            cnt_reg   <= cnt_next;
            ccmp_reg  <= ccmp_next;
            psk_reg   <= psk_next;
            grp_reg   <= grp_next;
            clen_reg  <= clen_next;
            sec_reg   <= sec_next;
            cbank_reg <= cbank_next;
        end
    end

endmodule

// ===== sv/wisp_cmd_fifo.sv =====
// Two-entry queue of drain requests between the parser and the output side.
module wisp_cmd_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  wisp_pkg::drain_cmd_t  push_cmd,
    input  logic                  pop,
    output wisp_pkg::drain_cmd_t  head,
    output wisp_pkg::fifo_stat_t  stat
);
    import wisp_pkg::*;

    drain_cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head = entry_reg[rd_ptr_reg];

    // Report fill level and which banks queued requests still need
    always_comb
    begin
        stat.full  = (count_reg == 2'd2);
        stat.empty = (count_reg == 2'd0);
        stat.pend  = '0;
        if (count_reg != 2'd0)
        begin
            stat.pend[entry_reg[rd_ptr_reg].bank] = 1'b1;
        end
        if (count_reg == 2'd2)
        begin
            stat.pend[entry_reg[~rd_ptr_reg].bank] = 1'b1;
        end
    end

    // Advance pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store a transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/wisp_back.sv =====
// Output side: SSID buffer, drain sequencer and result register.
module wisp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wisp_pkg::ssid_wr_t    ssid_wr,
    input  wisp_pkg::drain_cmd_t  head,
    input  logic                  fifo_empty,
    output logic                  pop,
    output wisp_pkg::back_stat_t  stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);
    import wisp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_BYTE,
        S_SUM
    } state_t;

    logic [7:0] mem [2*SSID_BYTES];

    state_t           state_reg, state_next;
    logic             bank_reg, bank_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       sec_reg, sec_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [7:0]       rd_data_reg;
    logic [LEN_W-1:0] idx_inc;

    assign idx_inc     = idx_reg + LEN_W'(1);
    assign pop         = (state_reg == S_IDLE) && !fifo_empty;
    assign stat.active = (state_reg != S_IDLE);
    assign stat.bank   = bank_reg;

    // Present the current result
    assign m_tvalid = (state_reg == S_BYTE) || (state_reg == S_SUM);
    assign m_tuser  = (state_reg == S_SUM) ? RES_SUMMARY : RES_SSID;
    assign m_tlast  = (state_reg == S_SUM);
    always_comb
    begin
        m_tdata        = '0;
        m_tdata[18:13] = len_reg;
        m_tdata[20:19] = sec_reg;
        if (state_reg == S_BYTE)
        begin
            m_tdata[7:0]  = rd_data_reg;
            m_tdata[12:8] = idx_reg[SSID_AW-1:0];
        end
    end

    // Sequence the drain: a buffer read and then a transaction per SSID byte, then the summary
    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        len_next   = len_reg;
        sec_next   = sec_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    bank_next  = head.bank;
                    len_next   = head.len;
                    sec_next   = head.sec;
                    idx_next   = '0;
                    state_next = (head.len == '0) ? S_SUM : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_BYTE;
            end
            S_BYTE:
            begin
                if (m_tready)
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == len_reg) ? S_SUM : S_READ;
                end
            end
            S_SUM:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bank_reg  <= 1'b0;
            len_reg   <= '0;
            sec_reg   <= SEC_UNKNOWN;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            len_reg   <= len_next;
            sec_reg   <= sec_next;
            idx_reg   <= idx_next;
        end
    end

    // SSID buffer: write staged bytes, read committed bytes
    always_ff @(posedge clk)
    begin
        if (ssid_wr.en)
        begin
            mem[ssid_wr.addr] <= ssid_wr.data;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[{bank_reg, idx_reg[SSID_AW-1:0]}];
        end
    end

endmodule

// ===== sv/wifi_ie_security_parser.sv =====
// Top level of the information-element security parser.
//
// Input stream: one blob byte per transaction on s_axis_tdata[7:0]; s_axis_tlast
// marks the final byte of a blob. The parser takes one byte per cycle when it is not stalled.
// Output stream: for each blob, one transaction per committed SSID byte
// (tuser = 0), then one summary (tuser = 1, tlast = 1) with SSID length and
// security class. Each SSID byte is first read from the buffer, then presented;
// the summary follows the last byte.
// The parser and the output side are joined by a two-entry request queue, so
// the next blob streams in while the previous one drains. The parser stalls
// only when the queue is full, or when an SSID byte would land in the buffer
// bank that a pending drain still has to read.
// Output stalls hold the current result; nothing is dropped.
// Reset clears all parser and drain state; the SSID buffer needs no clearing.
module wifi_ie_security_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] ssid_char, [12:8] ssid_position,
                                        // [18:13] ssid_length, [20:19] security
    output logic        m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast
);
    import wisp_pkg::*;

    fifo_stat_t fifo_stat;
    back_stat_t back_stat;
    drain_cmd_t push_cmd;
    drain_cmd_t head;
    ssid_wr_t   ssid_wr;
    logic       push;
    logic       pop;

    // Parse the byte stream
    wisp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tlast   (s_axis_tlast),
        .fifo_stat (fifo_stat),
        .back_stat (back_stat),
        .push      (push),
        .push_cmd  (push_cmd),
        .ssid_wr   (ssid_wr)
    );

    // Queue drain requests
    wisp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (fifo_stat)
    );

    // Drain SSID bytes and summary
    wisp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ssid_wr    (ssid_wr),
        .head       (head),
        .fifo_empty (fifo_stat.empty),
        .pop        (pop),
        .stat       (back_stat),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .m_tlast    (m_axis_tlast)
    );

endmodule
